### rtl/core/slh192_pkg.sv
// Package for the 192-bit SHA-1-like hash core.
// Shared constants, command/status structs; no dependencies.
`timescale 1ns / 1ps

package slh192_pkg;

    localparam int WORDS_PER_CHUNK = 16;
    localparam int NUM_CHAIN       = 6;
    localparam int NUM_ROUNDS      = 120;

    localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);
    localparam logic [2:0] LAST_WORD  = 3'(NUM_CHAIN - 1);

    // Round constants per phase
    localparam logic [31:0] K0 = 32'h5A82799A;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [31:0] K5 = 32'hDDB3D743;

    // Chaining start values
    localparam logic [31:0] CHAIN_INIT [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
        32'hC3D2A1F0, 32'h10325476, 32'hC3D2A1F0
    };

    // Controller to datapath
    typedef struct packed {
        logic       byte_wr;    // store input byte
        logic       pad_wr;     // store pad byte
        logic       pad_init;   // latch pad value from count after this byte
        logic       load;       // working words <= chain
        logic       round;      // one compression round
        logic [6:0] round_idx;
        logic       add;        // chain += working words
        logic       chain_rst;  // chain back to start values
        logic [2:0] word_sel;   // digest word on output
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic chunk_full;       // next byte write completes the chunk
    } dp_status_t;

endpackage

### rtl/core/sha1_like_192bit_hash_top.sv
// Top level of the 192-bit SHA-1-like hash core.
// Depends on slh192_pkg, slh192_ctrl, slh192_dp.
`timescale 1ns / 1ps

// Byte-serial hash with a 192-bit digest. Bytes are taken one per cycle
// while in_ready is high; is_last ends the message. Every 64th byte starts
// a compression (one load, 120 rounds on a single shared round unit, one
// add-back) during which no byte is taken. After the last byte the pad
// bytes are written one per cycle (up to 64), the final chunk is
// compressed, and six digest words follow, most significant first, one
// per output transfer; final_word marks the sixth. The core then returns
// to its start values and takes the next message.

module sha1_like_192bit_hash_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        final_word
);

    slh192_pkg::dp_cmd_t    cmd;
    slh192_pkg::dp_status_t status;

    // Sequencer
    slh192_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .word_index (word_index),
        .final_word (final_word),
        .status     (status),
        .cmd        (cmd)
    );

    // Buffer, chaining words and round logic
    slh192_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .status      (status),
        .digest_word (digest_word)
    );

endmodule

### rtl/core/slh192_dp.sv
// Datapath: chunk buffer, byte counter, chaining and working words, round logic.
// Depends on slh192_pkg.
`timescale 1ns / 1ps

module slh192_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  slh192_pkg::dp_cmd_t  cmd,
    input  logic [7:0]           data_byte,
    output slh192_pkg::dp_status_t status,
    output logic [31:0]          digest_word
);

    logic [31:0] chain_reg [slh192_pkg::NUM_CHAIN];
    logic [31:0] word_buf_reg [slh192_pkg::WORDS_PER_CHUNK];
    logic [5:0]  count_reg;
    logic [7:0]  pad_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg;

    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [5:0]  count_inc;
    logic [6:0]  pad_calc;
    logic [31:0] p_val;
    logic [31:0] k_val;
    logic [31:0] t_val;
    logic [31:0] w_val;

    assign wr_en     = cmd.byte_wr | cmd.pad_wr;
    assign wr_byte   = cmd.byte_wr ? data_byte : pad_reg;
    assign count_inc = count_reg + 6'd1;
    // pad count: 64 - bytes held after the last byte (0 held means 64)
    assign pad_calc  = 7'd64 - {1'b0, count_inc};

    assign status.chunk_full = (count_reg == 6'd63);
    assign digest_word       = chain_reg[cmd.word_sel];

    // Mixing function and constant by phase
    always_comb
    begin
        if (cmd.round_idx < 7'd20)
        begin
            p_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = slh192_pkg::K0;
        end
        else if (cmd.round_idx < 7'd40)
        begin
            p_val = b_reg ^ c_reg ^ d_reg;
            k_val = slh192_pkg::K1;
        end
        else if (cmd.round_idx < 7'd60)
        begin
            p_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = slh192_pkg::K2;
        end
        else if (cmd.round_idx < 7'd80)
        begin
            p_val = b_reg ^ c_reg ^ d_reg;
            k_val = slh192_pkg::K3;
        end
        else if (cmd.round_idx < 7'd100)
        begin
            p_val = (a_reg & c_reg) | (a_reg & d_reg) | (c_reg & d_reg);
            k_val = slh192_pkg::K3;
        end
        else
        begin
            p_val = c_reg ^ d_reg ^ e_reg;
            k_val = slh192_pkg::K5;
        end
    end

    assign w_val = word_buf_reg[cmd.round_idx[3:0]];
    assign t_val = {a_reg[4:0], a_reg[31:5]} + p_val + e_reg + k_val + w_val;

    // Byte counter and pad value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (wr_en)
        begin
            count_reg <= count_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pad_init)
        begin
            pad_reg <= {1'b0, pad_calc};
        end
    end

    // Chunk buffer, big-endian byte lanes
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            word_buf_reg[count_reg[5:2]][{~count_reg[1:0], 3'b000} +: 8] <= wr_byte;
        end
    end

    // Working words
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
            f_reg <= chain_reg[5];
        end
        else if (cmd.round)
        begin
            a_reg <= t_val;
            b_reg <= f_reg;
            c_reg <= {b_reg[29:0], b_reg[31:30]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // Chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < slh192_pkg::NUM_CHAIN; i++)
            begin
                chain_reg[i] <= slh192_pkg::CHAIN_INIT[i];
            end
        end
        else if (cmd.chain_rst)
        begin
            for (int i = 0; i < slh192_pkg::NUM_CHAIN; i++)
            begin
                chain_reg[i] <= slh192_pkg::CHAIN_INIT[i];
            end
        end
        else if (cmd.add)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg;
            chain_reg[5] <= chain_reg[5] + f_reg;
        end
    end

endmodule

### rtl/core/slh192_ctrl.sv
// Controller: sequences byte intake, padding, rounds, add-back and digest output.
// Depends on slh192_pkg.
`timescale 1ns / 1ps

module slh192_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   is_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             word_index,
    output logic                   final_word,
    input  slh192_pkg::dp_status_t status,
    output slh192_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    // Where to go once a chunk is compressed
    localparam logic [1:0] AFT_IDLE = 2'd0;
    localparam logic [1:0] AFT_PAD  = 2'd1;
    localparam logic [1:0] AFT_EMIT = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] after_reg, after_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] idx_reg,   idx_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_EMIT);
    assign in_xfer    = in_valid & in_ready;
    assign out_xfer   = out_valid & out_ready;
    assign word_index = idx_reg;
    assign final_word = (idx_reg == slh192_pkg::LAST_WORD);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        cmd           = '0;
        cmd.round_idx = round_reg;
        cmd.word_sel  = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd.byte_wr  = 1'b1;
                    cmd.pad_init = is_last;
                    if (status.chunk_full)
                    begin
                        state_next = ST_LOAD;
                        after_next = is_last ? AFT_PAD : AFT_IDLE;
                    end
                    else if (is_last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.pad_wr = 1'b1;
                if (status.chunk_full)
                begin
                    state_next = ST_LOAD;
                    after_next = AFT_EMIT;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == slh192_pkg::LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.add  = 1'b1;
                idx_next = '0;
                unique case (after_reg)
                    AFT_PAD:  state_next = ST_PAD;
                    AFT_EMIT: state_next = ST_EMIT;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    if (idx_reg == slh192_pkg::LAST_WORD)
                    begin
                        cmd.chain_rst = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            after_reg <= AFT_IDLE;
            round_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

### tb/slh192_digest_checker.sv
`timescale 1ns / 1ps
// Digest checker for sha1_like_192bit_hash_top: follows the byte stream and predicts
// the six digest words of every message, then compares them on the output channel.
// Self-contained; needs no package.

module slh192_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        final_word,
    output int          mismatches,
    output int          pending,
    output int          words_checked
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    localparam logic [31:0] IV_WORDS [6] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
        32'hC3D2A1F0, 32'h10325476, 32'hC3D2A1F0
    };
    localparam logic [31:0] RC_CHOOSE = 32'h5A82799A;
    localparam logic [31:0] RC_PARITY = 32'h6ED9EBA1;
    localparam logic [31:0] RC_MAJ    = 32'h8F1BBCDC;
    localparam logic [31:0] RC_LATE   = 32'hCA62C1D6;
    localparam logic [31:0] RC_TAIL   = 32'hDDB3D743;

    logic [31:0]  chain_h [6];
    logic [31:0]  chunk_words [16];
    logic [5:0]   chunk_fill;
    logic [6:0]   pad_count;
    digest_beat_t digest_q [$];
    digest_beat_t head_beat;

    // Store one byte big-endian; the 64th byte of a chunk runs the 120-round compression
    function automatic void absorb_byte(input logic [7:0] value);
        logic [31:0] a, b, c, d, e, f, mix, rc, t;
        chunk_words[chunk_fill[5:2]][8 * (3 - chunk_fill[1:0]) +: 8] = value;
        chunk_fill = chunk_fill + 6'd1;
        if (chunk_fill == 6'd0)
        begin
            a = chain_h[0];
            b = chain_h[1];
            c = chain_h[2];
            d = chain_h[3];
            e = chain_h[4];
            f = chain_h[5];
            for (int r = 0; r < 120; r++)
            begin
                if (r < 20)
                begin
                    mix = (b & c) | (~b & d);
                    rc  = RC_CHOOSE;
                end
                else if (r < 40)
                begin
                    mix = b ^ c ^ d;
                    rc  = RC_PARITY;
                end
                else if (r < 60)
                begin
                    mix = (b & c) | (b & d) | (c & d);
                    rc  = RC_MAJ;
                end
                else if (r < 80)
                begin
                    mix = b ^ c ^ d;
                    rc  = RC_LATE;
                end
                else if (r < 100)
                begin
                    // majority over a, c, d in this phase
                    mix = (a & c) | (a & d) | (c & d);
                    rc  = RC_LATE;
                end
                else
                begin
                    mix = c ^ d ^ e;
                    rc  = RC_TAIL;
                end
                t = {a[4:0], a[31:5]} + mix + e + rc + chunk_words[r % 16];
                e = d;
                d = c;
                c = {b[29:0], b[31:30]};
                b = f;  // f never changes
                a = t;
            end
            chain_h[0] += a;
            chain_h[1] += b;
            chain_h[2] += c;
            chain_h[3] += d;
            chain_h[4] += e;
            chain_h[5] += f;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                chain_h[i] = IV_WORDS[i];
            chunk_fill = '0;
            digest_q.delete();
            mismatches    = 0;
            words_checked = 0;
            pending <= 0;
        end
        else
        begin
            // Input transfer: absorb, and on the last byte pad and queue the digest
            if (in_valid && in_ready)
            begin
                absorb_byte(data_byte);
                if (is_last)
                begin
                    // a full chunk already gets 64 bytes of 0x40
                    pad_count = 7'd64 - {1'b0, chunk_fill};
                    repeat (pad_count)
                        absorb_byte({1'b0, pad_count});
                    for (int i = 0; i < 6; i++)
                        digest_q.push_back('{word: chain_h[i], index: 3'(i), last: (i == 5)});
                    for (int i = 0; i < 6; i++)
                        chain_h[i] = IV_WORDS[i];
                    chunk_fill = '0;
                end
            end

            // Output transfer: compare with the oldest queued word
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                begin
                    $display("%0t: unexpected digest transfer: word %h index %0d final %b",
                             $time, digest_word, word_index, final_word);
                    mismatches++;
                end
                else
                begin
                    head_beat = digest_q.pop_front();
                    words_checked++;
                    if (digest_word !== head_beat.word)
                    begin
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, head_beat.word, digest_word);
                        mismatches++;
                    end
                    if (word_index !== head_beat.index)
                    begin
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, head_beat.index, word_index);
                        mismatches++;
                    end
                    if (final_word !== head_beat.last)
                    begin
                        $display("%0t: final_word expected %b actual %b",
                                 $time, head_beat.last, final_word);
                        mismatches++;
                    end
                end
            end
            pending <= digest_q.size();
        end
    end

endmodule

### tb/tb_sha1_like_192bit_hash_top.sv
`timescale 1ns / 1ps
// Testbench top for sha1_like_192bit_hash_top: clock, reset, message stimulus,
// output back-pressure and the verdict. Depends on the DUT and slh192_digest_checker.

module tb_sha1_like_192bit_hash_top;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [7:0]  data_byte  = 8'h00;
    logic        is_last    = 1'b0;
    logic        out_ready  = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;

    logic        quiet_tail = 1'b0;
    int          ready_hold = 0;
    int          mismatches;
    int          pending;
    int          words_checked;
    int          bytes_sent    = 0;
    int          messages_sent = 0;

    sha1_like_192bit_hash_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .is_last     (is_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .final_word  (final_word)
    );

    slh192_digest_checker digest_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .is_last       (is_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .digest_word   (digest_word),
        .word_index    (word_index),
        .final_word    (final_word),
        .mismatches    (mismatches),
        .pending       (pending),
        .words_checked (words_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the core hangs
    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // Output back-pressure: alternating ready runs and stall bursts, always ready at the end
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_hold <= 0;
        end
        else if (quiet_tail)
            out_ready <= 1'b1;
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (out_ready)
        begin
            out_ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 18);
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 39);
        end
    end

    // Send one message, one byte per transfer; optional random gaps before bytes
    task automatic send_message(input logic [7:0] payload [$], input bit gaps_on);
        for (int i = 0; i < payload.size(); i++)
        begin
            if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            in_valid  <= 1'b1;
            data_byte <= payload[i];
            is_last   <= (i == payload.size() - 1);
            do
                @(posedge clk);
            while (in_ready !== 1'b1);
            bytes_sent++;
        end
        messages_sent++;
    endtask

    initial
    begin
        logic [7:0] msg [$];
        int         len;
        int         msg_no;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-byte extremes, zero data, short mixed messages
        msg = {8'h00};
        send_message(msg, 1'b0);
        msg = {8'hFF};
        send_message(msg, 1'b0);
        msg = {8'h80, 8'h01};
        send_message(msg, 1'b0);
        msg = {8'h00, 8'h00, 8'h00};
        send_message(msg, 1'b1);
        msg = {8'hFF, 8'hFE, 8'h7F, 8'h01, 8'h55, 8'hAA, 8'h5A, 8'hA5};
        send_message(msg, 1'b1);
        msg = {8'h3C};
        send_message(msg, 1'b1);

        // Hold off until every queued digest word has drained
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);

        // Random messages; one chunk-aligned and one 65-byte length first, then a mix of short and long
        msg_no = 0;
        while (bytes_sent < 380)
        begin
            case (msg_no)
                0: len = 64;
                1: len = 65;
                default:
                    case ($urandom_range(0, 7))
                        0: len = 64;
                        1: len = 128;
                        2: len = 63;
                        default: len = $urandom_range(1, 40);
                    endcase
            endcase
            // keep the total byte count near the target
            if (bytes_sent + len > 390)
                len = 390 - bytes_sent;
            msg.delete();
            repeat (len) msg.push_back(8'($urandom));
            if (bytes_sent >= 330)
                quiet_tail <= 1'b1;
            send_message(msg, $urandom_range(0, 3) != 0);
            msg_no++;
        end

        // Drain and let the core settle
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (30) @(posedge clk);

        $display("Hashed %0d messages (%0d bytes), lengths from 1 byte to two full chunks,",
                 messages_sent, bytes_sent);
        $display("with %0d digest words compared under random stalls on both channels.",
                 words_checked);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
